>>> rtl/core/dwva_pkg.sv
// ----------------------------------------------------------------------------
// Drowsiness window vote alarm package
// Transaction types, configuration register indexes and reset values shared
// by the drowsiness window vote alarm.
// ----------------------------------------------------------------------------
package dwva_pkg;

  // Eye opening values: unsigned fixed point, 10 fraction bits (1024 = 1.0).
  localparam int unsigned EyeW     = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEFT_THRESHOLD  = 3'd0,
    CFG_RIGHT_THRESHOLD = 3'd1,
    CFG_WIN_WIDTH       = 3'd2,
    CFG_VOTE_THRESHOLD  = 3'd3,
    CFG_RESET_PERIOD    = 3'd4,
    CFG_ALARMS_ENABLED  = 3'd5,
    CFG_SOUND_ENABLED   = 3'd6
  } cfg_index_e;

  // Reset values: 0.3 and 0.5 truncated to fixed point, 80-frame window,
  // 20 closed frames, period of 256 frames, both alarms enabled.
  localparam logic [EyeW-1:0] LeftThresholdRst  = 11'd307;
  localparam logic [EyeW-1:0] RightThresholdRst = 11'd512;
  localparam logic [6:0]      WindowWidthRst    = 7'd80;
  localparam logic [7:0]      VoteThresholdRst  = 8'd20;
  localparam logic [7:0]      ResetPeriodRst    = 8'd0;

  // Number of episodes that trigger an escalation.
  localparam logic [1:0]      EscalateEpisodes  = 2'd3;

  typedef struct packed {
    logic            detecting;
    logic            face_found;
    logic [EyeW-1:0] left_open;
    logic [EyeW-1:0] right_open;
  } frame_in_t;

  typedef struct packed {
    logic voted;
    logic sleepy;
    logic sound_pulse;
    logic escalate_pulse;
  } vote_out_t;

endpackage

>>> rtl/core/drowsiness_window_vote_alarm.sv
// ----------------------------------------------------------------------------
// Drowsiness window vote alarm
// Sliding-window vote over per-frame eyes-closed flags with episode alarms.
// ----------------------------------------------------------------------------
// Each input transaction is one camera frame. While detecting, the block keeps
// a window of eyes-closed flags (a frame is closed when both eye openings are
// below their thresholds) and, once the window holds one flag more than the
// configured width, votes on it: more closed flags than vote_threshold means
// sleepy. The oldest
// flag is dropped at each vote. A rising edge of the vote starts an episode
// that raises sound_pulse, and every third episode also raises escalate_pulse.
// An 8-bit frame counter clears the episode counter every reset_period frames
// (zero meaning 256). Frames with detecting low produce an all-zero result and
// leave the state untouched. Every frame gives exactly one result transaction.
// Throughput is one frame per clock cycle while the skid register is empty,
// and results are registered. The whole update is a handful of compares and
// counter steps done in the acceptance cycle; the flag ring is a one-bit-wide
// memory of WINDOW_DEPTH entries, written at the tail and read ahead at the
// next head address into a register, so the oldest flag is ready when
// the next frame arrives. No clearing pass is needed after reset: only flags
// written since reset are ever read. A two-entry output stage (result register
// plus skid register) lets the block take a new frame while a result waits.
// Configuration may be written only while the block is idle.
// ----------------------------------------------------------------------------
module drowsiness_window_vote_alarm
  import dwva_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Frame input channel.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  frame_in_t           in_data_i,
  // Result output channel.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vote_out_t           out_data_o,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CmpW = (CntW > 8) ? CntW : 8;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [EyeW-1:0] left_thr_q, right_thr_q;
  logic [6:0]      win_width_q;
  logic [7:0]      vote_thr_q;
  logic [7:0]      reset_period_q;
  logic            alarms_en_q, sound_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_thr_q     <= LeftThresholdRst;
      right_thr_q    <= RightThresholdRst;
      win_width_q    <= WindowWidthRst;
      vote_thr_q     <= VoteThresholdRst;
      reset_period_q <= ResetPeriodRst;
      alarms_en_q    <= 1'b1;
      sound_en_q     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_LEFT_THRESHOLD:  left_thr_q     <= cfg_data_i;
        CFG_RIGHT_THRESHOLD: right_thr_q    <= cfg_data_i;
        CFG_WIN_WIDTH:       win_width_q    <= cfg_data_i[6:0];
        CFG_VOTE_THRESHOLD:  vote_thr_q     <= cfg_data_i[7:0];
        CFG_RESET_PERIOD:    reset_period_q <= cfg_data_i[7:0];
        CFG_ALARMS_ENABLED:  alarms_en_q    <= cfg_data_i[0];
        CFG_SOUND_ENABLED:   sound_en_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Window and episode state
  // --------------------------------------------------------------------------
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] closed_q, closed_d;
  logic            latch_q, latch_d;
  logic [1:0]      episode_q, episode_d;
  logic [7:0]      frame_q, frame_d;

  // Oldest flag, read ahead from the ring.
  logic            oldest_q;

  logic            accept;
  logic            out_load_ok;
  vote_out_t       result;

  // Ring write request.
  logic            ring_we;
  logic [IdxW-1:0] ring_waddr;
  logic            ring_wdata;

  // Intermediate values of the update.
  logic [CmpW-1:0] width_eff, width_ext, width_lim;
  logic            vote, sleepy;
  logic [IdxW-1:0] head_mid;
  logic [CntW-1:0] fill_mid, closed_mid;
  logic [CntW:0]   tail_sum;
  logic            push, closed_flag;
  logic [7:0]      frame_inc;
  logic [1:0]      episode_inc;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    width_ext = CmpW'(win_width_q);
    width_lim = CmpW'(WINDOW_DEPTH - 1);
    width_eff = (width_ext > width_lim) ? width_lim : width_ext;

    head_d      = head_q;
    fill_d      = fill_q;
    closed_d    = closed_q;
    latch_d     = latch_q;
    episode_d   = episode_q;
    frame_d     = frame_q;
    result      = '0;
    ring_we     = 1'b0;
    ring_waddr  = '0;
    ring_wdata  = 1'b0;
    vote        = 1'b0;
    sleepy      = 1'b0;
    head_mid    = head_q;
    fill_mid    = fill_q;
    closed_mid  = closed_q;
    tail_sum    = '0;
    push        = 1'b0;
    episode_inc = episode_q + 2'd1;
    frame_inc   = frame_q + 8'd1;
    closed_flag = (in_data_i.left_open < left_thr_q) &&
                  (in_data_i.right_open < right_thr_q);

    if (accept && in_data_i.detecting) begin
      // Frame counter, with periodic clearing of the episode counter.
      frame_d = frame_inc;
      if (frame_inc == reset_period_q) begin
        frame_d   = '0;
        episode_d = '0;
      end
      episode_inc = episode_d + 2'd1;

      // Vote when the window holds more than the effective width.
      vote = CmpW'(fill_q) > width_eff;
      if (vote) begin
        sleepy     = CmpW'(closed_q) > CmpW'(vote_thr_q);
        closed_mid = closed_q - CntW'(oldest_q);
        head_mid   = (head_q == IdxW'(WINDOW_DEPTH - 1)) ? '0 : head_q + IdxW'(1);
        fill_mid   = fill_q - CntW'(1);
        result.voted  = 1'b1;
        result.sleepy = sleepy;
        if (sleepy) begin
          if (!latch_q) begin
            // New episode.
            episode_d = episode_inc;
            if (episode_inc == 2'd1) begin
              frame_d = '0;
            end
            result.sound_pulse = alarms_en_q && sound_en_q;
            if (episode_inc == EscalateEpisodes) begin
              episode_d             = '0;
              result.escalate_pulse = alarms_en_q;
            end
            latch_d = 1'b1;
          end
        end else begin
          latch_d = 1'b0;
        end
      end

      // Push this frame's flag at the tail of the window.
      push = in_data_i.face_found && (fill_mid < CntW'(WINDOW_DEPTH));
      tail_sum = (CntW + 1)'(head_mid) + (CntW + 1)'(fill_mid);
      if (tail_sum >= (CntW + 1)'(WINDOW_DEPTH)) begin
        tail_sum = tail_sum - (CntW + 1)'(WINDOW_DEPTH);
      end
      ring_we    = push;
      ring_waddr = tail_sum[IdxW-1:0];
      ring_wdata = closed_flag;

      head_d   = head_mid;
      fill_d   = push ? fill_mid + CntW'(1) : fill_mid;
      closed_d = push ? closed_mid + CntW'(closed_flag) : closed_mid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      fill_q    <= '0;
      closed_q  <= '0;
      latch_q   <= 1'b0;
      episode_q <= '0;
      frame_q   <= '0;
    end else begin
      head_q    <= head_d;
      fill_q    <= fill_d;
      closed_q  <= closed_d;
      latch_q   <= latch_d;
      episode_q <= episode_d;
      frame_q   <= frame_d;
    end
  end

  // --------------------------------------------------------------------------
  // Flag ring memory. The read address is the head for the next frame; a
  // write to that same entry in this cycle is forwarded to the read register.
  // --------------------------------------------------------------------------
  logic ring_mem [WINDOW_DEPTH];

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    if (ring_we && (ring_waddr == head_d)) begin
      oldest_q <= ring_wdata;
    end else begin
      oldest_q <= ring_mem[head_d];
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: result register with a skid register behind it.
  // --------------------------------------------------------------------------
  logic      out_valid_q, skid_valid_q;
  vote_out_t out_q, skid_q;
  logic      pop;

  assign in_ready_o  = !skid_valid_q;
  assign pop         = out_valid_q && out_ready_i;
  assign out_load_ok = !out_valid_q || pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_load_ok) begin
        out_valid_q  <= skid_valid_q || accept;
        skid_valid_q <= 1'b0;
      end else if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load_ok) begin
      out_q <= skid_valid_q ? skid_q : result;
    end else if (accept) begin
      skid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // The window never holds more flags than the ring has entries.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(WINDOW_DEPTH))
    else $error("window fill level exceeds ring depth");

  // Closed flags are a subset of the flags held.
  a_closed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q <= fill_q)
    else $error("closed count exceeds fill level");

  // The episode counter wraps before reaching the escalation count.
  a_episode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    episode_q != EscalateEpisodes)
    else $error("episode counter reached escalation count");

  // Any alarm pulse comes only from a sleepy vote.
  a_pulse_needs_vote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.sound_pulse || out_q.escalate_pulse)
      |-> out_q.voted && out_q.sleepy)
    else $error("alarm pulse without a sleepy vote");

  // The skid register only fills behind a stalled result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q && $past(out_valid_q && !out_ready_i))
    else $error("skid register holds a result with the output stage free");
`endif

endmodule

>>> verif/drowsiness_window_vote_alarm_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Drowsiness window vote alarm testbench
// Drives camera frame transactions into the vote alarm and checks every result
// transaction against a cycle-free predictor of the window, vote and episode
// logic. A short directed table comes first, then random frame bursts under a
// new register setting per phase and three idling patterns.
// ----------------------------------------------------------------------------
module drowsiness_window_vote_alarm_test;
  import dwva_pkg::*;

  localparam int unsigned Depth       = 128;
  localparam int unsigned PhaseFrames = 203;
  localparam int unsigned NumPhases   = 9;
  localparam int unsigned NumRows     = 36;
  localparam int unsigned MaxReports  = 100;

  // A directed row either writes one register or sends one frame. Frames whose
  // result is obvious carry it in the table; the others go to the predictor.
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_FRAME,
    ROW_FRAME_KNOWN
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    cfg_index_e           reg_idx;
    logic [CfgDataW-1:0]  value;
    logic                 detecting;
    logic                 face_found;
    logic [EyeW-1:0]      left_open;
    logic [EyeW-1:0]      right_open;
    vote_out_t            want;
  } stim_row_t;

  localparam stim_row_t Plan [NumRows] = '{
    // Detection off: the frame is ignored even with a face and shut eyes.
    '{ROW_FRAME_KNOWN, CFG_LEFT_THRESHOLD, 11'd0, 1'b0, 1'b1, 11'd0, 11'd0, 4'b0000},
    // Empty window after reset, then a few flags at the reset thresholds.
    // Eye values above 1.0 are compared as they are.
    '{ROW_FRAME_KNOWN, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b0, 11'd2047, 11'd2047, 4'b0000},
    '{ROW_FRAME_KNOWN, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b1, 11'd2047, 11'd2047, 4'b0000},
    '{ROW_FRAME_KNOWN, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b1, 11'd306, 11'd511, 4'b0000},
    '{ROW_FRAME_KNOWN, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b1, 11'd307, 11'd0, 4'b0000},
    '{ROW_FRAME_KNOWN, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b1, 11'd0, 11'd512, 4'b0000},
    // Window width zero: a vote whenever one flag is held, so the window that
    // was filled above drains one flag per frame.
    '{ROW_CFG, CFG_WIN_WIDTH, 11'd0, 1'b0, 1'b0, 11'd0, 11'd0, 4'b0000},
    '{ROW_CFG, CFG_VOTE_THRESHOLD, 11'd0, 1'b0, 1'b0, 11'd0, 11'd0, 4'b0000},
    '{ROW_CFG, CFG_RESET_PERIOD, 11'd255, 1'b0, 1'b0, 11'd0, 11'd0, 4'b0000},
    '{ROW_FRAME, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b1, 11'd0, 11'd0, 4'b0000},
    '{ROW_FRAME, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b0, 11'd1024, 11'd1024, 4'b0000},
    '{ROW_FRAME, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b0, 11'd1024, 11'd1024, 4'b0000},
    '{ROW_FRAME, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b0, 11'd1024, 11'd1024, 4'b0000},
    '{ROW_FRAME, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b0, 11'd1024, 11'd1024, 4'b0000},
    '{ROW_FRAME_KNOWN, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b0, 11'd1024, 11'd1024, 4'b0000},
    // Alternating shut and open frames: the vote toggles, and every rising
    // edge is a new episode, and the third episode since reset escalates.
    '{ROW_FRAME, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b1, 11'd0, 11'd0, 4'b0000},
    '{ROW_FRAME, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b1, 11'd1024, 11'd1024, 4'b0000},
    '{ROW_FRAME, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b1, 11'd0, 11'd0, 4'b0000},
    '{ROW_FRAME, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b1, 11'd1024, 11'd1024, 4'b0000},
    '{ROW_FRAME, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b1, 11'd0, 11'd0, 4'b0000},
    '{ROW_FRAME, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b1, 11'd1024, 11'd1024, 4'b0000},
    // Sound muted on its own, then the master enable off.
    '{ROW_CFG, CFG_SOUND_ENABLED, 11'd0, 1'b0, 1'b0, 11'd0, 11'd0, 4'b0000},
    '{ROW_FRAME, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b1, 11'd0, 11'd0, 4'b0000},
    '{ROW_FRAME, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b1, 11'd1024, 11'd1024, 4'b0000},
    '{ROW_CFG, CFG_ALARMS_ENABLED, 11'd0, 1'b0, 1'b0, 11'd0, 11'd0, 4'b0000},
    '{ROW_CFG, CFG_SOUND_ENABLED, 11'd1, 1'b0, 1'b0, 11'd0, 11'd0, 4'b0000},
    '{ROW_FRAME, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b1, 11'd0, 11'd0, 4'b0000},
    '{ROW_FRAME, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b1, 11'd1024, 11'd1024, 4'b0000},
    // Thresholds and width at the top, with the episode counter cleared each frame.
    '{ROW_CFG, CFG_LEFT_THRESHOLD, 11'd2047, 1'b0, 1'b0, 11'd0, 11'd0, 4'b0000},
    '{ROW_CFG, CFG_RIGHT_THRESHOLD, 11'd2047, 1'b0, 1'b0, 11'd0, 11'd0, 4'b0000},
    '{ROW_CFG, CFG_WIN_WIDTH, 11'd127, 1'b0, 1'b0, 11'd0, 11'd0, 4'b0000},
    '{ROW_CFG, CFG_VOTE_THRESHOLD, 11'd128, 1'b0, 1'b0, 11'd0, 11'd0, 4'b0000},
    '{ROW_CFG, CFG_RESET_PERIOD, 11'd1, 1'b0, 1'b0, 11'd0, 11'd0, 4'b0000},
    '{ROW_CFG, CFG_ALARMS_ENABLED, 11'd1, 1'b0, 1'b0, 11'd0, 11'd0, 4'b0000},
    '{ROW_FRAME, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b1, 11'd2047, 11'd2047, 4'b0000},
    '{ROW_FRAME, CFG_LEFT_THRESHOLD, 11'd0, 1'b1, 1'b1, 11'd2046, 11'd1025, 4'b0000}
  };

  // Block ports. Every input has a known value from time zero.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  frame_in_t           in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  vote_out_t           out_data_o;
  logic                cfg_we_i    = 1'b0;
  cfg_index_e          cfg_index_i = CFG_LEFT_THRESHOLD;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Idling percentages of the frame sender and of the result receiver.
  int unsigned send_idle  = 28;
  int unsigned recv_stall = 82;

  // Shape of the random eye data: bursts of mostly shut or mostly open eyes.
  int unsigned shut_pct   = 50;
  int unsigned burst_left = 0;

  // Predictor copy of the registers.
  logic [EyeW-1:0] thr_left  = LeftThresholdRst;
  logic [EyeW-1:0] thr_right = RightThresholdRst;
  logic [6:0]      win_width = WindowWidthRst;
  logic [7:0]      vote_thr  = VoteThresholdRst;
  logic [7:0]      period    = ResetPeriodRst;
  logic            alarm_en  = 1'b1;
  logic            sound_en  = 1'b1;

  // Predictor copy of the window and episode state. Ring entries are only
  // read after they have been written, so the ring needs no reset value.
  logic                     closed_ring [Depth];
  logic [$clog2(Depth)-1:0] oldest      = '0;
  logic [7:0]               held_flags  = '0;
  logic [7:0]               closed_held = '0;
  logic                     in_episode  = 1'b0;
  logic [1:0]               episode_cnt = '0;
  logic [7:0]               frame_cnt   = '0;

  // Results expected from the block, oldest first, and run statistics.
  vote_out_t pending_votes [$];
  int unsigned field_errors   = 0;
  int unsigned checked_frames = 0;
  int unsigned votes_seen     = 0;
  int unsigned sleepy_seen    = 0;
  int unsigned sound_seen     = 0;
  int unsigned escalate_seen  = 0;

  drowsiness_window_vote_alarm #(
    .WINDOW_DEPTH(Depth)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Works out the result of one accepted frame and advances the predictor
  // state. The order of the steps matters: the frame counter and its periodic
  // clear come first, then the vote on the window as it stood before this
  // frame, and only then the push of this frame's own flag.
  function automatic vote_out_t predict_vote(frame_in_t frame);
    vote_out_t                result;
    int unsigned              width;
    logic                     eyes_shut;
    logic [$clog2(Depth)-1:0] slot;
    result = '0;
    width  = (win_width > Depth - 1) ? Depth - 1 : int'(win_width);
    if (frame.detecting) begin
      frame_cnt = frame_cnt + 8'd1;
      // A period of zero matches when the counter wraps, i.e. every 256 frames.
      if (frame_cnt == period) begin
        frame_cnt   = '0;
        episode_cnt = '0;
      end
      if (held_flags > width) begin
        result.voted  = 1'b1;
        result.sleepy = (closed_held > vote_thr);
        if (closed_ring[oldest]) begin
          closed_held = closed_held - 8'd1;
        end
        // The ring index wraps with its own width.
        oldest     = oldest + 1'b1;
        held_flags = held_flags - 8'd1;
        if (result.sleepy) begin
          // Only the first sleepy vote of a run opens a new episode.
          if (!in_episode) begin
            episode_cnt = episode_cnt + 2'd1;
            if (episode_cnt == 2'd1) begin
              frame_cnt = '0;
            end
            result.sound_pulse = alarm_en & sound_en;
            if (episode_cnt == EscalateEpisodes) begin
              episode_cnt           = '0;
              result.escalate_pulse = alarm_en;
            end
            in_episode = 1'b1;
          end
        end else begin
          in_episode = 1'b0;
        end
      end
      if (frame.face_found && held_flags < Depth) begin
        eyes_shut = (frame.left_open < thr_left) && (frame.right_open < thr_right);
        // The tail slot wraps with the ring index width.
        slot = oldest + held_flags[$clog2(Depth)-1:0];
        closed_ring[slot] = eyes_shut;
        held_flags  = held_flags + 8'd1;
        closed_held = closed_held + {7'd0, eyes_shut};
      end
    end
    return result;
  endfunction

  // Eye opening for random frames: below the threshold when the eye is meant
  // to be shut, otherwise mostly within 0..1.0 and sometimes above it.
  function automatic logic [EyeW-1:0] eye_value(logic shut, logic [EyeW-1:0] limit);
    if (shut && limit != '0) begin
      return EyeW'($urandom_range(0, int'(limit) - 1));
    end
    if ($urandom_range(0, 3) == 0) begin
      return EyeW'($urandom_range(0, 2047));
    end
    return EyeW'($urandom_range(0, 1024));
  endfunction

  // Random frame. Most frames are detecting frames with a face, so the window
  // fills and votes; the rest are ignored frames and frames without a face.
  function automatic frame_in_t random_frame();
    frame_in_t frame;
    logic      shut;
    if (burst_left == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          shut_pct = 3;
        end
        1: begin
          shut_pct = 50;
        end
        default: begin
          shut_pct = 97;
        end
      endcase
      burst_left = $urandom_range(4, 40);
    end
    burst_left       = burst_left - 1;
    frame.detecting  = ($urandom_range(0, 99) >= 8);
    frame.face_found = ($urandom_range(0, 99) >= 10);
    shut             = ($urandom_range(0, 99) < shut_pct);
    frame.left_open  = eye_value(shut, thr_left);
    frame.right_open = eye_value(shut, thr_right);
    return frame;
  endfunction

  // Threshold for a random phase, with the ends of the field now and then.
  function automatic logic [CfgDataW-1:0] pick_threshold();
    case ($urandom_range(0, 7))
      0: begin
        return '0;
      end
      1: begin
        return CfgDataW'(1024);
      end
      2: begin
        return CfgDataW'(2047);
      end
      default: begin
        return CfgDataW'($urandom_range(1, 1023));
      end
    endcase
  endfunction

  // Reports one result field that differs from the prediction.
  function automatic void check_field(string name, logic want, logic got);
    if (got !== want) begin
      if (field_errors < MaxReports) begin
        $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
      end
      field_errors++;
    end
  endfunction

  // Writes one register and mirrors it in the predictor. The write enable is
  // left high so back-to-back writes need one assignment per cycle; the caller
  // lowers it after the last write.
  task automatic write_reg(input cfg_index_e idx, input logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      CFG_LEFT_THRESHOLD: begin
        thr_left = value;
      end
      CFG_RIGHT_THRESHOLD: begin
        thr_right = value;
      end
      CFG_WIN_WIDTH: begin
        win_width = value[6:0];
      end
      CFG_VOTE_THRESHOLD: begin
        vote_thr = value[7:0];
      end
      CFG_RESET_PERIOD: begin
        period = value[7:0];
      end
      CFG_ALARMS_ENABLED: begin
        alarm_en = value[0];
      end
      CFG_SOUND_ENABLED: begin
        sound_en = value[0];
      end
      default: begin
      end
    endcase
  endtask

  // Sends one frame transaction after a random gap and records its expected
  // result at the edge where it is accepted. A result typed into the table
  // replaces the prediction; the predictor still runs to keep its state.
  task automatic send_frame(input frame_in_t frame, input logic typed, input vote_out_t want);
    vote_out_t predicted;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= frame;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    predicted = predict_vote(frame);
    pending_votes = {pending_votes, (typed ? want : predicted)};
  endtask

  // Stops sending and waits until every result has come back, so that the
  // block is idle before its registers change.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_votes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (2) @(posedge clk_i);
  endtask

  // Result side: a random ready pattern, and a field-by-field check of every
  // result transaction against the oldest outstanding prediction.
  always @(posedge clk_i) begin : result_check
    vote_out_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_votes.size() == 0) begin
        if (field_errors < MaxReports) begin
          $display("%0t: result %b arrived with no frame outstanding", $time, out_data_o);
        end
        field_errors++;
      end else begin
        want = pending_votes.pop_front();
        check_field("voted", want.voted, out_data_o.voted);
        check_field("sleepy", want.sleepy, out_data_o.sleepy);
        check_field("sound_pulse", want.sound_pulse, out_data_o.sound_pulse);
        check_field("escalate_pulse", want.escalate_pulse, out_data_o.escalate_pulse);
        checked_frames++;
        votes_seen    += int'(want.voted);
        sleepy_seen   += int'(want.sleepy);
        sound_seen    += int'(want.sound_pulse);
        escalate_seen += int'(want.escalate_pulse);
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall);
  end

  initial begin : stimulus
    frame_in_t   frame;
    logic        in_cfg;
    int unsigned width;
    int unsigned sent;
    in_cfg = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, run with a slow sender and a slower receiver.
    for (int row = 0; row < NumRows; row++) begin
      if (Plan[row].kind == ROW_CFG) begin
        if (!in_cfg) begin
          wait_drained();
        end
        write_reg(Plan[row].reg_idx, Plan[row].value);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) begin
          cfg_we_i <= 1'b0;
        end
        in_cfg           = 1'b0;
        frame.detecting  = Plan[row].detecting;
        frame.face_found = Plan[row].face_found;
        frame.left_open  = Plan[row].left_open;
        frame.right_open = Plan[row].right_open;
        send_frame(frame, Plan[row].kind == ROW_FRAME_KNOWN, Plan[row].want);
      end
    end

    // Random phases. Each phase writes every register while the block is idle;
    // since the window keeps its contents, a narrower width than before makes
    // the window drain one flag per frame. Small widths dominate so that votes
    // and episodes are frequent.
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase / 3)
        0: begin
          send_idle  = 28;
          recv_stall = 82;
        end
        1: begin
          send_idle  = 82;
          recv_stall = 28;
        end
        default: begin
          send_idle  = 0;
          recv_stall = 0;
        end
      endcase
      wait_drained();
      case ($urandom_range(0, 9))
        0: begin
          width = 0;
        end
        1: begin
          width = 127;
        end
        2: begin
          width = $urandom_range(17, 126);
        end
        default: begin
          width = $urandom_range(1, 16);
        end
      endcase
      write_reg(CFG_LEFT_THRESHOLD, pick_threshold());
      write_reg(CFG_RIGHT_THRESHOLD, pick_threshold());
      write_reg(CFG_WIN_WIDTH, CfgDataW'(width));
      case ($urandom_range(0, 7))
        0: begin
          write_reg(CFG_VOTE_THRESHOLD, '0);
        end
        1: begin
          write_reg(CFG_VOTE_THRESHOLD, CfgDataW'(128));
        end
        2: begin
          write_reg(CFG_VOTE_THRESHOLD, CfgDataW'(255));
        end
        default: begin
          write_reg(CFG_VOTE_THRESHOLD, CfgDataW'($urandom_range(0, width + 1)));
        end
      endcase
      case ($urandom_range(0, 5))
        0: begin
          write_reg(CFG_RESET_PERIOD, '0);
        end
        1: begin
          write_reg(CFG_RESET_PERIOD, CfgDataW'(1));
        end
        2: begin
          write_reg(CFG_RESET_PERIOD, CfgDataW'(255));
        end
        default: begin
          write_reg(CFG_RESET_PERIOD, CfgDataW'($urandom_range(2, 254)));
        end
      endcase
      write_reg(CFG_ALARMS_ENABLED, CfgDataW'($urandom_range(0, 3) != 0));
      write_reg(CFG_SOUND_ENABLED, CfgDataW'($urandom_range(0, 3) != 0));
      cfg_we_i <= 1'b0;

      // Every frame, ignored or not, counts toward the phase length.
      sent = 0;
      while (sent < PhaseFrames) begin
        frame = random_frame();
        send_frame(frame, 1'b0, '0);
        sent++;
      end
    end

    // Let every result come back, then leave room for any stray extra one.
    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Checked %0d frame results over %0d register settings and three idling patterns.",
             checked_frames, NumPhases + 1);
    $display("Seen: %0d votes, %0d sleepy, %0d sound pulses, %0d escalations.",
             votes_seen, sleepy_seen, sound_seen, escalate_seen);
    if (field_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of about 1850 frames.
  initial begin : watchdog
    #5_000_000;
    $display("Watchdog expired with %0d results outstanding", pending_votes.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
